// File: hw/rtl/lslf_pkg.sv
// Shared types, constants and control encodings for the least-squares line fit.
package lslf_pkg;

  localparam int MAX_POINTS_DEF    = 4096;
  localparam int OUT_FRAC_BITS_DEF = 16;
  localparam int COORD_W           = 16;
  localparam int COEF_W            = 32;
  localparam int COUNT_OUT_W       = 13;
  // Binary point of the input coordinates.
  localparam int IN_FRAC_BITS      = 8;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } lslf_in_t;

  typedef struct packed {
    logic signed [COEF_W-1:0]  coef_a;
    logic signed [COEF_W-1:0]  coef_c;
    logic                      degenerate;
    logic [COUNT_OUT_W-1:0]    point_count;
  } lslf_out_t;

  // Product codes: bits [2:1] pick the target (denominator, slope numerator,
  // offset numerator), bit 0 set means subtract from it.
  localparam logic [2:0] OP_N_SXX  = 3'd0;
  localparam logic [2:0] OP_SX_SX  = 3'd1;
  localparam logic [2:0] OP_N_SXY  = 3'd2;
  localparam logic [2:0] OP_SX_SY  = 3'd3;
  localparam logic [2:0] OP_SY_SXX = 3'd4;
  localparam logic [2:0] OP_SX_SXY = 3'd5;

  localparam logic DIV_SLOPE  = 1'b0;
  localparam logic DIV_OFFSET = 1'b1;

  typedef struct packed {
    logic       mul_go;
    logic [2:0] mul_op;
    logic       div_go;
    logic       div_sel;
    logic       emit;
    logic       degen;
  } lslf_cmd_t;

  typedef struct packed {
    logic pipe_idle;
    logic mul_done;
    logic div_done;
    logic den_zero;
  } lslf_sts_t;

endpackage

// File: hw/rtl/lslf_ctrl.sv
// Sequencer for the line fit: drain, products, zero check, divisions, emit.
module lslf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  in_last,
  input  lslf_pkg::lslf_sts_t   sts,
  output logic                  busy,
  output lslf_pkg::lslf_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DRAIN,
    S_MUL_GO,
    S_MUL_WAIT,
    S_CHECK,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DONE
  } state_t;

  state_t              state_r;
  logic                busy_r;
  logic [2:0]          op_r;
  logic                dsel_r;
  lslf_pkg::lslf_cmd_t cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      op_r    <= lslf_pkg::OP_N_SXX;
      dsel_r  <= lslf_pkg::DIV_SLOPE;
      cmd_r   <= '0;
    end else begin
      cmd_r.mul_go <= 1'b0;
      cmd_r.div_go <= 1'b0;
      cmd_r.emit   <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start && in_last) begin
            state_r <= S_DRAIN;
            busy_r  <= 1'b1;
          end
        end
        S_DRAIN: begin
          // wait for the final point to land in the sums
          if (sts.pipe_idle) begin
            op_r    <= lslf_pkg::OP_N_SXX;
            state_r <= S_MUL_GO;
          end
        end
        S_MUL_GO: begin
          cmd_r.mul_go <= 1'b1;
          cmd_r.mul_op <= op_r;
          state_r      <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (sts.mul_done) begin
            if (op_r == lslf_pkg::OP_SX_SXY) begin
              state_r <= S_CHECK;
            end else begin
              op_r    <= op_r + 3'd1;
              state_r <= S_MUL_GO;
            end
          end
        end
        S_CHECK: begin
          if (sts.den_zero) begin
            cmd_r.emit  <= 1'b1;
            cmd_r.degen <= 1'b1;
            state_r     <= S_DONE;
          end else begin
            dsel_r  <= lslf_pkg::DIV_SLOPE;
            state_r <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          cmd_r.div_go  <= 1'b1;
          cmd_r.div_sel <= dsel_r;
          state_r       <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (sts.div_done) begin
            if (dsel_r == lslf_pkg::DIV_OFFSET) begin
              cmd_r.emit  <= 1'b1;
              cmd_r.degen <= 1'b0;
              state_r     <= S_DONE;
            end else begin
              dsel_r  <= lslf_pkg::DIV_OFFSET;
              state_r <= S_DIV_GO;
            end
          end
        end
        S_DONE: begin
          busy_r  <= 1'b0;
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign busy = busy_r;
  assign cmd  = cmd_r;

endmodule

// File: hw/rtl/lslf_datapath.sv
// Point accumulator, bit-serial multiplier and restoring divider for the fit.
module lslf_datapath #(
  parameter int MAX_POINTS    = lslf_pkg::MAX_POINTS_DEF,
  parameter int OUT_FRAC_BITS = lslf_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_take,
  input  lslf_pkg::lslf_in_t   in_data,
  input  lslf_pkg::lslf_cmd_t  cmd,
  output lslf_pkg::lslf_sts_t  sts,
  output logic                 out_valid,
  output lslf_pkg::lslf_out_t  out_data
);

  localparam int LOG_N  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int CW     = lslf_pkg::COORD_W;
  localparam int SX_W   = CW + LOG_N;
  localparam int SQ_W   = 2 * CW + LOG_N;
  localparam int MW     = SQ_W;
  localparam int PW     = 2 * MW;
  localparam int NUM_W  = PW + OUT_FRAC_BITS;
  localparam int MCW    = $clog2(MW + 1);
  localparam int DCW    = $clog2(NUM_W + 2);
  localparam int OW     = lslf_pkg::COEF_W;
  localparam int SH_A   = OUT_FRAC_BITS;
  localparam int SH_C   = OUT_FRAC_BITS - lslf_pkg::IN_FRAC_BITS;

  // ---------------- accumulation pipeline ----------------
  logic                  s1_v_r, s2_v_r;
  logic signed [CW-1:0]  s1_x_r, s1_y_r, s2_x_r, s2_y_r;
  logic signed [2*CW-1:0] s2_xx_r, s2_xy_r;
  logic [CNT_W-1:0]      count_r;
  logic signed [SX_W-1:0] sum_x_r, sum_y_r;
  logic signed [SQ_W-1:0] sum_xy_r, sum_xx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_take;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_x_r  <= in_data.x;
    s1_y_r  <= in_data.y;
    s2_x_r  <= s1_x_r;
    s2_y_r  <= s1_y_r;
    s2_xx_r <= s1_x_r * s1_x_r;
    s2_xy_r <= s1_x_r * s1_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      count_r  <= '0;
      sum_x_r  <= '0;
      sum_y_r  <= '0;
      sum_xy_r <= '0;
      sum_xx_r <= '0;
    end else if (s2_v_r && (count_r < CNT_W'(MAX_POINTS))) begin
      count_r  <= count_r + CNT_W'(1);
      sum_x_r  <= sum_x_r + SX_W'(s2_x_r);
      sum_y_r  <= sum_y_r + SX_W'(s2_y_r);
      sum_xy_r <= sum_xy_r + SQ_W'(s2_xy_r);
      sum_xx_r <= sum_xx_r + SQ_W'(s2_xx_r);
    end
  end

  // ---------------- shift-add multiplier ----------------
  logic signed [MW-1:0] mul_a, mul_b, mag_a, mag_b;
  logic [PW-1:0]        mcand_r, prod_r;
  logic [MW-1:0]        mplier_r;
  logic [MCW-1:0]       mcnt_r;
  logic                 mbusy_r, msign_r, mdone_r;
  logic [2:0]           mop_r;
  logic signed [PW-1:0] den_r, na_r, nc_r, prod_s, tgt;

  always_comb begin
    case (cmd.mul_op)
      lslf_pkg::OP_N_SXX:  begin mul_a = MW'($signed({1'b0, count_r})); mul_b = MW'(sum_xx_r); end
      lslf_pkg::OP_SX_SX:  begin mul_a = MW'(sum_x_r);  mul_b = MW'(sum_x_r);  end
      lslf_pkg::OP_N_SXY:  begin mul_a = MW'($signed({1'b0, count_r})); mul_b = MW'(sum_xy_r); end
      lslf_pkg::OP_SX_SY:  begin mul_a = MW'(sum_x_r);  mul_b = MW'(sum_y_r);  end
      lslf_pkg::OP_SY_SXX: begin mul_a = MW'(sum_y_r);  mul_b = MW'(sum_xx_r); end
      lslf_pkg::OP_SX_SXY: begin mul_a = MW'(sum_x_r);  mul_b = MW'(sum_xy_r); end
      default:             begin mul_a = '0;            mul_b = '0;            end
    endcase
    mag_a  = mul_a[MW-1] ? -mul_a : mul_a;
    mag_b  = mul_b[MW-1] ? -mul_b : mul_b;
    prod_s = msign_r ? -$signed(prod_r) : $signed(prod_r);
    case (mop_r[2:1])
      2'd0:    tgt = den_r;
      2'd1:    tgt = na_r;
      default: tgt = nc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      mdone_r <= 1'b0;
    end else begin
      mdone_r <= 1'b0;
      if (cmd.mul_go) begin
        mbusy_r <= 1'b1;
      end else if (mbusy_r && (mcnt_r == MCW'(MW))) begin
        mbusy_r <= 1'b0;
        mdone_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      mcand_r  <= PW'(unsigned'(mag_a));
      mplier_r <= mag_b;
      prod_r   <= '0;
      mcnt_r   <= '0;
      msign_r  <= mul_a[MW-1] ^ mul_b[MW-1];
      mop_r    <= cmd.mul_op;
    end else if (mbusy_r && (mcnt_r != MCW'(MW))) begin
      if (mplier_r[0]) begin
        prod_r <= prod_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
      mcnt_r   <= mcnt_r + MCW'(1);
    end else if (mbusy_r) begin
      // write the product back: set on the first term, subtract on the second
      case (mop_r[2:1])
        2'd0:    den_r <= mop_r[0] ? tgt - prod_s : prod_s;
        2'd1:    na_r  <= mop_r[0] ? tgt - prod_s : prod_s;
        default: nc_r  <= mop_r[0] ? tgt - prod_s : prod_s;
      endcase
    end
  end

  // ---------------- restoring divider ----------------
  logic signed [PW-1:0] dsrc;
  logic [PW-1:0]        dmag;
  logic [NUM_W-1:0]     dnum_r, q_r, lim, qsat;
  logic [PW-1:0]        rem_r;
  logic [PW:0]          trial, tdiff;
  logic                 ge;
  logic [DCW-1:0]       dcnt_r;
  logic                 dbusy_r, ddone_r, dneg_r, dsel_r;
  logic [OW-1:0]        res;
  logic signed [OW-1:0] coef_a_r, coef_c_r;

  always_comb begin
    dsrc  = cmd.div_sel ? nc_r : na_r;
    dmag  = dsrc[PW-1] ? unsigned'(-dsrc) : unsigned'(dsrc);
    trial = {rem_r, dnum_r[NUM_W-1]};
    tdiff = trial - {1'b0, den_r};
    ge    = !tdiff[PW];
    lim   = dneg_r ? (NUM_W'(1) << (OW - 1)) : ((NUM_W'(1) << (OW - 1)) - NUM_W'(1));
    qsat  = (q_r > lim) ? lim : q_r;
    res   = dneg_r ? -qsat[OW-1:0] : qsat[OW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      ddone_r <= 1'b0;
    end else begin
      ddone_r <= 1'b0;
      if (cmd.div_go) begin
        dbusy_r <= 1'b1;
      end else if (dbusy_r && (dcnt_r == DCW'(NUM_W + 1))) begin
        dbusy_r <= 1'b0;
        ddone_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      dnum_r <= cmd.div_sel ? (NUM_W'(dmag) << SH_C) : (NUM_W'(dmag) << SH_A);
      rem_r  <= '0;
      q_r    <= '0;
      dcnt_r <= '0;
      dneg_r <= !dsrc[PW-1];
      dsel_r <= cmd.div_sel;
    end else if (dbusy_r) begin
      dcnt_r <= dcnt_r + DCW'(1);
      if (dcnt_r < DCW'(NUM_W)) begin
        rem_r  <= ge ? tdiff[PW-1:0] : trial[PW-1:0];
        q_r    <= {q_r[NUM_W-2:0], ge};
        dnum_r <= dnum_r << 1;
      end else if (dcnt_r == DCW'(NUM_W)) begin
        // round half away from zero on the magnitude
        if ({rem_r, 1'b0} >= {1'b0, den_r}) begin
          q_r <= q_r + NUM_W'(1);
        end
      end else if (dsel_r == lslf_pkg::DIV_OFFSET) begin
        coef_c_r <= res;
      end else begin
        coef_a_r <= res;
      end
    end
  end

  // ---------------- result beat ----------------
  logic                out_valid_r;
  lslf_pkg::lslf_out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.coef_a      <= cmd.degen ? '0 : coef_a_r;
      out_r.coef_c      <= cmd.degen ? '0 : coef_c_r;
      out_r.degenerate  <= cmd.degen;
      out_r.point_count <= lslf_pkg::COUNT_OUT_W'(count_r);
    end
  end

  assign sts.pipe_idle = !s1_v_r && !s2_v_r;
  assign sts.mul_done  = mdone_r;
  assign sts.div_done  = ddone_r;
  assign sts.den_zero  = (den_r == '0);
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

// File: hw/rtl/least_squares_line_fit.sv
// Top level of the streaming least-squares line fit.
//
// Points (x, y in signed Q8.8) enter one per beat: a beat is taken at a
// rising edge with start high and busy low, and while points are being summed
// busy stays low, so the block takes one point every cycle. The beat that
// carries last = 1 closes the set: busy then rises and the block computes the
// line coef_a*x + y + coef_c = 0 (coef_a = -slope, coef_c = -intercept, signed
// Q16.16 by default, rounded half away from zero and saturated to 32 bits).
// The fit runs on a bit-serial shift-add multiplier that forms six wide
// products (operands of MW = 32 + log2(MAX_POINTS) bits, 44 by default) and
// a restoring divider that yields one quotient bit a cycle (numerator of
// NUM_W = 2*MW + OUT_FRAC_BITS bits, 104 by default). A final point keeps
// busy high until the result goes out; a set whose denominator is zero skips
// the divisions and reports degenerate = 1 with both coefficients zero. The
// result beat shows on out_data for exactly one cycle, marked by out_valid,
// in the first cycle that busy is low again; it cannot be held off, so
// capture it then. Points past MAX_POINTS are dropped from the sums, but a
// final point still starts the fit. Sums and count clear as the result goes
// out.
module least_squares_line_fit #(
  parameter int MAX_POINTS    = lslf_pkg::MAX_POINTS_DEF,
  parameter int OUT_FRAC_BITS = lslf_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lslf_pkg::lslf_in_t  in_data,
  output logic                out_valid,
  output lslf_pkg::lslf_out_t out_data
);

  lslf_pkg::lslf_cmd_t cmd;
  lslf_pkg::lslf_sts_t sts;
  logic                in_take;

  // accept a point only while the sequencer is idle
  assign in_take = start && !busy;

  lslf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_take),
    .in_last (in_data.last),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  lslf_datapath #(
    .MAX_POINTS    (MAX_POINTS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (in_take),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // a result beat only ever follows a busy fit
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a preceding fit");

  // a degenerate set carries zero coefficients
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.degenerate) |-> (out_data.coef_a == '0 && out_data.coef_c == '0))
    else $error("degenerate result with nonzero coefficients");

  // busy rises only after a final point was taken
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && in_data.last))
    else $error("busy rose without a final point");

endmodule

// File: sim/lslf_fit_checker.sv
// Checker for the line fit: watches point and result beats, predicts each fit, compares.
module lslf_fit_checker
  import lslf_pkg::*;
#(
  parameter int MAX_POINTS    = MAX_POINTS_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  lslf_in_t  in_data,
  input  logic      out_valid,
  input  lslf_out_t out_data,
  output int        fail_count,
  output int        pending_fits,
  output int        fits_seen,
  output int        degenerate_seen
);

  lslf_out_t   fit_queue[$];
  int          acc_count;
  longint      acc_x, acc_y, acc_xy, acc_xx;

  // Return -(num * 2^shift) / den, rounded half away from zero, saturated.
  function automatic logic [COEF_W-1:0] scaled_quotient(input logic signed [127:0] num,
                                                        input int shift,
                                                        input logic [127:0] den);
    logic        neg;
    logic [191:0] mag, q, r, lim;
    neg = num[127];
    mag = neg ? 192'(-num) : 192'(num);
    mag = mag << shift;
    q = mag / den;
    r = mag % den;
    if (r >= den - r) q = q + 1;
    lim = neg ? 192'h7FFF_FFFF : 192'h8000_0000;
    if (q > lim) q = lim;
    return neg ? q[COEF_W-1:0] : -q[COEF_W-1:0];
  endfunction

  function automatic lslf_out_t line_from_sums();
    logic signed [127:0] n, sx, sy, sxy, sxx, den, num_a, num_c;
    lslf_out_t res;
    n = acc_count; sx = acc_x; sy = acc_y; sxy = acc_xy; sxx = acc_xx;
    den = n * sxx - sx * sx;
    res = '0;
    res.point_count = acc_count[COUNT_OUT_W-1:0];
    if (den == 0) begin
      res.degenerate = 1'b1;
    end else begin
      num_a = n * sxy - sx * sy;
      num_c = sy * sxx - sx * sxy;
      res.coef_a = scaled_quotient(num_a, OUT_FRAC_BITS, den);
      res.coef_c = scaled_quotient(num_c, OUT_FRAC_BITS - IN_FRAC_BITS, den);
    end
    return res;
  endfunction

  assign pending_fits = fit_queue.size();

  always @(posedge clk) begin
    longint    px, py;
    lslf_out_t want;
    if (!rst_n) begin
      acc_count = 0; acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0;
      fail_count <= 0; fits_seen <= 0; degenerate_seen <= 0;
      fit_queue.delete();
    end else begin
      if (out_valid) begin
        if (fit_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected fit result %p", out_data);
        end else begin
          want = fit_queue.pop_front();
          fits_seen <= fits_seen + 1;
          if (out_data.degenerate) degenerate_seen <= degenerate_seen + 1;
          if (out_data.coef_a !== want.coef_a || out_data.coef_c !== want.coef_c ||
              out_data.degenerate !== want.degenerate ||
              out_data.point_count !== want.point_count) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("fit mismatch: want a=%0d c=%0d deg=%0b n=%0d got a=%0d c=%0d deg=%0b n=%0d",
                       $signed(want.coef_a), $signed(want.coef_c), want.degenerate,
                       want.point_count, $signed(out_data.coef_a),
                       $signed(out_data.coef_c), out_data.degenerate,
                       out_data.point_count);
          end
        end
      end
      if (start && !busy) begin
        px = in_data.x;
        py = in_data.y;
        // Drop points beyond capacity from the sums; a closing point still fits.
        if (acc_count < MAX_POINTS) begin
          acc_count = acc_count + 1;
          acc_x = acc_x + px;
          acc_y = acc_y + py;
          acc_xy = acc_xy + px * py;
          acc_xx = acc_xx + px * px;
        end
        if (in_data.last) begin
          fit_queue = {fit_queue, line_from_sums()};
          acc_count = 0; acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0;
        end
      end
    end
  end

endmodule

// File: sim/tb_least_squares_line_fit.sv
// Testbench top for the line fit: drives point sets and reports the verdict.
module tb_least_squares_line_fit;
  import lslf_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  lslf_in_t  in_data = '0;
  logic      out_valid;
  lslf_out_t out_data;
  int        fail_count, pending_fits, fits_seen, degenerate_seen;
  int        points_sent = 0;
  bit        calm = 1'b0;

  always #2 clk = ~clk;

  least_squares_line_fit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  lslf_fit_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .fail_count(fail_count),
    .pending_fits(pending_fits), .fits_seen(fits_seen),
    .degenerate_seen(degenerate_seen)
  );

  // Drive one point beat and hold it until the block takes it. start stays
  // high afterwards so back-to-back beats need no second assignment.
  task automatic send_point(input logic [15:0] px, input logic [15:0] py,
                            input logic fin);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_data <= '{x: px, y: py, last: fin};
    @(posedge clk);
    while (busy) @(posedge clk);
    points_sent++;
  endtask

  // Pick a coordinate: mostly full range, some extremes, some small values.
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2, 3: return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_set(input int size, input bit same_x);
    logic [15:0] fixed_x;
    fixed_x = pick_coord();
    for (int i = 0; i < size; i++)
      send_point(same_x ? fixed_x : pick_coord(), pick_coord(), i == size - 1);
  endtask

  initial begin
    #10_000_000;
    $display("[least_squares_line_fit] ERROR");
    $finish;
  end

  initial begin
    int size;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: a lone point, equal x, extreme corners, saturating slopes.
    send_point(16'h8000, 16'h7FFF, 1'b1);
    send_point(16'h7FFF, 16'h8000, 1'b1);
    send_point(16'h0100, 16'h0000, 1'b0);
    send_point(16'h0100, 16'h7FFF, 1'b0);
    send_point(16'h0100, 16'h8000, 1'b1);
    send_point(16'h0000, 16'h8000, 1'b0);
    send_point(16'h0001, 16'h7FFF, 1'b1);
    send_point(16'h0000, 16'h7FFF, 1'b0);
    send_point(16'h0001, 16'h8000, 1'b1);
    send_point(16'h8000, 16'h8000, 1'b0);
    send_point(16'h7FFF, 16'h7FFF, 1'b1);
    send_point(16'h8000, 16'h7FFF, 1'b0);
    send_point(16'h7FFF, 16'h8000, 1'b0);
    send_point(16'h0000, 16'h0000, 1'b1);
    send_point(16'hFF00, 16'h0000, 1'b0);
    send_point(16'h0100, 16'h0200, 1'b1);
    send_point(16'h0000, 16'h0000, 1'b0);
    send_point(16'h0000, 16'h0000, 1'b1);

    // Hold off until every pending fit has come back.
    @(negedge clk);
    start <= 1'b0;
    while (pending_fits != 0) @(negedge clk);

    // Random sets, mostly small, some with a constant x.
    while (points_sent < 680) begin
      size = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
      if (points_sent > 550) calm = 1'b1;
      send_set(size, $urandom_range(0, 9) == 0);
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_fits != 0) @(negedge clk);
    repeat (600) @(negedge clk);

    $display("sent %0d points; %0d fits checked, %0d of them degenerate",
             points_sent, fits_seen, degenerate_seen);
    if (fail_count == 0 && pending_fits == 0) begin
      $display("[least_squares_line_fit] OK");
    end else begin
      $display("[least_squares_line_fit] ERROR");
    end
    $finish;
  end

endmodule
